### sv/rsad_pkg.sv
// Package with the item types, constants and codes of the range sensor avoidance drive unit.
package rsad_pkg;

  // Drive mode codes as carried in the result item.
  typedef enum logic [1:0] {
    MODE_REVERSE  = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_AVOID    = 2'd2
  } drive_mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CLEAR_DISTANCE   = 3'd0,
    REG_OPEN_DISTANCE    = 3'd1,
    REG_CROWD_DISTANCE   = 3'd2,
    REG_REVERSE_DURATION = 3'd3,
    REG_REVERSE_HOLDOFF  = 3'd4
  } cfg_reg_e;

  // Register reset values.
  localparam logic [15:0] CLEAR_DISTANCE_RST   = 16'd100;
  localparam logic [15:0] OPEN_DISTANCE_RST    = 16'd1000;
  localparam logic [15:0] CROWD_DISTANCE_RST   = 16'd250;
  localparam logic [15:0] REVERSE_DURATION_RST = 16'd1000;
  localparam logic [15:0] REVERSE_HOLDOFF_RST  = 16'd3000;

  // cos(30 deg) in Q16.
  localparam logic [15:0] COS30_Q16 = 16'd56756;

  // Blocked time limit: BLOCK_NUM / speed ms, clamped to the short and long limits.
  localparam int BLOCK_NUM      = 5000;
  localparam int LIMIT_LONG_MS  = 200;
  localparam int LIMIT_SHORT_MS = 30;
  localparam int SPEED_LONG_LIM  = BLOCK_NUM / LIMIT_LONG_MS;   // below: long limit
  localparam int SPEED_SHORT_LIM = BLOCK_NUM / LIMIT_SHORT_MS;  // above: short limit

  // Speed commands in thousandths.
  localparam logic signed [10:0] SPEED_REVERSE = -11'sd300;
  localparam logic signed [10:0] SPEED_OPEN    = 11'sd750;
  localparam logic signed [10:0] SPEED_MIN     = 11'sd300;
  localparam logic signed [10:0] SPEED_MAX     = 11'sd750;

  // Turn commands in thousandths.
  localparam logic signed [13:0] TURN_FULL  = 14'sd7000;
  localparam logic signed [13:0] TURN_CROWD = 14'sd3000;
  localparam logic signed [13:0] TURN_GAIN  = 14'sd14;
  localparam int DIFF_REVERSE = 150;
  localparam int DIFF_AVOID   = 500;

  // Blink periods in ms.
  localparam logic [9:0] BLINK_REVERSE  = 10'd100;
  localparam logic [9:0] BLINK_STRAIGHT = 10'd1000;
  localparam logic [9:0] BLINK_AVOID    = 10'd333;

  // One input item.
  typedef struct packed {
    logic [15:0] dist_far_right;
    logic [15:0] dist_mid_right;
    logic [15:0] dist_center;
    logic [15:0] dist_mid_left;
    logic [15:0] dist_far_left;
    logic [31:0] time_ms;
  } rsad_item_t;

  // Configuration registers.
  typedef struct packed {
    logic [15:0] clear_distance_mm;
    logic [15:0] open_distance_mm;
    logic [15:0] crowd_distance_mm;
    logic [15:0] reverse_duration_ms;
    logic [15:0] reverse_holdoff_ms;
  } rsad_cfg_t;

  // Per-item results that depend on the ranges and configuration only.
  typedef struct packed {
    logic               clear_ok;
    logic               open_ok;
    logic signed [13:0] reverse_turn;
    logic signed [10:0] avoid_speed;
    logic signed [13:0] avoid_turn;
  } rsad_feat_t;

endpackage

### sv/rsad_feat.sv
// Range evaluation: clear path, open sides and the candidate reverse and avoidance commands.
module rsad_feat
  import rsad_pkg::*;
(
  input  rsad_item_t item_i,
  input  rsad_cfg_t  cfg_i,
  output rsad_feat_t feat_o
);

  logic [31:0]        clear_lim;
  logic [31:0]        mid_left_prod;
  logic [31:0]        mid_right_prod;
  logic signed [16:0] rev_diff;
  logic signed [16:0] avoid_diff;
  logic signed [9:0]  avoid_clamped;
  logic signed [13:0] avoid_scaled;
  logic               crowded;
  logic [15:0]        min_a;
  logic [15:0]        min_b;
  logic [15:0]        min_c;
  logic [15:0]        min_all;

  // The angled sensors see the path through cos(30 deg).
  assign clear_lim      = {cfg_i.clear_distance_mm, 16'h0000};
  assign mid_left_prod  = {16'h0000, item_i.dist_mid_left} * {16'h0000, COS30_Q16};
  assign mid_right_prod = {16'h0000, item_i.dist_mid_right} * {16'h0000, COS30_Q16};

  assign feat_o.clear_ok = (item_i.dist_center > cfg_i.clear_distance_mm)
                         && (mid_left_prod > clear_lim)
                         && (mid_right_prod > clear_lim);

  assign feat_o.open_ok = (item_i.dist_far_left > cfg_i.open_distance_mm)
                        && (item_i.dist_mid_left > cfg_i.open_distance_mm)
                        && (item_i.dist_mid_right > cfg_i.open_distance_mm)
                        && (item_i.dist_far_right > cfg_i.open_distance_mm);

  assign crowded = (item_i.dist_far_left < cfg_i.crowd_distance_mm)
                 && (item_i.dist_far_right < cfg_i.crowd_distance_mm);

  // Reverse turn: a far-sensor difference of DIFF_REVERSE or more either way gives a full turn, else none.
  assign rev_diff = $signed({1'b0, item_i.dist_far_left}) - $signed({1'b0, item_i.dist_far_right});

  always_comb begin
    if (rev_diff >= 17'(DIFF_REVERSE)) begin
      feat_o.reverse_turn = TURN_FULL;
    end else if (rev_diff <= -17'(DIFF_REVERSE)) begin
      feat_o.reverse_turn = -TURN_FULL;
    end else begin
      feat_o.reverse_turn = 14'sd0;
    end
  end

  // Smallest range over all five sensors.
  assign min_a   = (item_i.dist_mid_left < item_i.dist_far_left) ?
                   item_i.dist_mid_left : item_i.dist_far_left;
  assign min_b   = (item_i.dist_mid_right < item_i.dist_center) ?
                   item_i.dist_mid_right : item_i.dist_center;
  assign min_c   = (min_b < min_a) ? min_b : min_a;
  assign min_all = (item_i.dist_far_right < min_c) ? item_i.dist_far_right : min_c;

  // Avoidance speed is twice the smallest range, clamped.
  always_comb begin
    if (min_all < 16'(SPEED_MIN / 2)) begin
      feat_o.avoid_speed = SPEED_MIN;
    end else if (min_all > 16'(SPEED_MAX / 2)) begin
      feat_o.avoid_speed = SPEED_MAX;
    end else begin
      feat_o.avoid_speed = $signed({min_all[9:0], 1'b0});
    end
  end

  // Avoidance turn follows the angled sensor difference.
  assign avoid_diff = $signed({1'b0, item_i.dist_mid_right})
                    - $signed({1'b0, item_i.dist_mid_left});

  always_comb begin
    if (avoid_diff > 17'(DIFF_AVOID)) begin
      avoid_clamped = 10'(DIFF_AVOID);
    end else if (avoid_diff < -17'(DIFF_AVOID)) begin
      avoid_clamped = -10'(DIFF_AVOID);
    end else begin
      avoid_clamped = avoid_diff[9:0];
    end
  end

  assign avoid_scaled = 14'(avoid_clamped) * TURN_GAIN;

  // With both outer sensors crowded the turn gets the tighter limit.
  always_comb begin
    if (crowded && (avoid_scaled > TURN_CROWD)) begin
      feat_o.avoid_turn = TURN_CROWD;
    end else if (crowded && (avoid_scaled < -TURN_CROWD)) begin
      feat_o.avoid_turn = -TURN_CROWD;
    end else begin
      feat_o.avoid_turn = avoid_scaled;
    end
  end

endmodule

### sv/range_sensor_avoidance_drive_unit.sv
// Top level of the range sensor avoidance drive unit: item pipeline, drive state and config.
// Path: an input item loads into the input register at the accepting edge, then passes
// through the range evaluation register and the result register.
// Throughput: one item per cycle while the result output is not held back; the drive state
// is updated in the decision stage, so each item sees the state left by the one before it.
// Reset clears the pipeline, the drive state and loads the register defaults.
module range_sensor_avoidance_drive_unit
  import rsad_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input items.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: time_ms[32], dist_far_left[16], dist_mid_left[16],
  // dist_center[16], dist_mid_right[16], dist_far_right[16]
  input  logic [111:0] s_axis_tdata,
  // Result items.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: drive_mode[2], speed_milli[11], turn_milli[14],
  // blink_period_ms[10], zero fill[3]
  output logic [39:0]  m_axis_tdata,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);

  rsad_cfg_t  cfg_q;
  rsad_item_t item_q;
  logic       in_valid_q;
  rsad_feat_t feat_w;
  rsad_feat_t feat_q;
  logic [31:0] time2_q;
  logic        dec_valid_q;

  logic        out_valid_q;
  drive_mode_e mode_q;
  logic signed [10:0] speed_q;
  logic signed [13:0] turn_q;
  logic [9:0]  blink_q;

  logic [31:0] clear_path_time_q, clear_path_time_d;
  logic [31:0] reverse_deadline_q, reverse_deadline_d;
  logic [31:0] reverse_seen_time_q, reverse_seen_time_d;
  logic signed [10:0] prior_speed_q;

  logic out_ready;
  logic dec_ready;
  logic in_ready;
  logic dec_fire;

  logic [31:0] blocked_elapsed;
  logic [39:0] blocked_prod;
  logic        blocked;
  logic        trigger;
  logic        reversing;
  drive_mode_e mode_d;
  logic signed [10:0] speed_d;
  logic signed [13:0] turn_d;
  logic [9:0]  blink_d;

  // Each stage moves on when it is empty or the stage after it moves.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign dec_ready     = !dec_valid_q || out_ready;
  assign in_ready      = !in_valid_q || dec_ready;
  assign s_axis_tready = in_ready;
  assign dec_fire      = dec_valid_q && out_ready;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clear_distance_mm   <= CLEAR_DISTANCE_RST;
      cfg_q.open_distance_mm    <= OPEN_DISTANCE_RST;
      cfg_q.crowd_distance_mm   <= CROWD_DISTANCE_RST;
      cfg_q.reverse_duration_ms <= REVERSE_DURATION_RST;
      cfg_q.reverse_holdoff_ms  <= REVERSE_HOLDOFF_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CLEAR_DISTANCE:   cfg_q.clear_distance_mm   <= cfg_data_i;
        REG_OPEN_DISTANCE:    cfg_q.open_distance_mm    <= cfg_data_i;
        REG_CROWD_DISTANCE:   cfg_q.crowd_distance_mm   <= cfg_data_i;
        REG_REVERSE_DURATION: cfg_q.reverse_duration_ms <= cfg_data_i;
        REG_REVERSE_HOLDOFF:  cfg_q.reverse_holdoff_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      item_q <= s_axis_tdata;
    end
  end

  rsad_feat u_feat (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .feat_o (feat_w)
  );

  // Range evaluation register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_valid_q <= 1'b0;
    end else if (dec_ready) begin
      dec_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_ready && in_valid_q) begin
      feat_q  <= feat_w;
      time2_q <= item_q.time_ms;
    end
  end

  // Clear path time and time blocked since then.
  assign clear_path_time_d = feat_q.clear_ok ? time2_q : clear_path_time_q;
  assign blocked_elapsed   = time2_q - clear_path_time_d;
  assign blocked_prod      = {8'h00, blocked_elapsed} * {32'h0000_0000, prior_speed_q[7:0]};

  // Blocked limit of BLOCK_NUM / speed ms, clamped, compared by cross-multiplying.
  always_comb begin
    if (prior_speed_q <= 11'sd0) begin
      blocked = (prior_speed_q == 11'sd0) ? (blocked_elapsed > 32'(LIMIT_LONG_MS))
                                          : (blocked_elapsed > 32'(LIMIT_SHORT_MS));
    end else if (prior_speed_q < 11'(SPEED_LONG_LIM)) begin
      blocked = blocked_elapsed > 32'(LIMIT_LONG_MS);
    end else if (prior_speed_q > 11'(SPEED_SHORT_LIM)) begin
      blocked = blocked_elapsed > 32'(LIMIT_SHORT_MS);
    end else begin
      blocked = blocked_prod > 40'(BLOCK_NUM);
    end
  end

  // Reverse trigger and release.
  assign trigger = blocked && (reverse_deadline_q == 32'd0)
                 && ((time2_q - reverse_seen_time_q) > 32'(cfg_q.reverse_holdoff_ms));

  always_comb begin
    if (trigger) begin
      reverse_deadline_d = time2_q + 32'(cfg_q.reverse_duration_ms);
    end else if (reverse_deadline_q < time2_q) begin
      reverse_deadline_d = 32'd0;
    end else begin
      reverse_deadline_d = reverse_deadline_q;
    end
  end

  assign reversing           = time2_q < reverse_deadline_d;
  assign reverse_seen_time_d = reversing ? time2_q : reverse_seen_time_q;

  // Command selection.
  always_comb begin
    if (reversing) begin
      mode_d  = MODE_REVERSE;
      speed_d = SPEED_REVERSE;
      turn_d  = feat_q.reverse_turn;
      blink_d = BLINK_REVERSE;
    end else if (feat_q.open_ok) begin
      mode_d  = MODE_STRAIGHT;
      speed_d = SPEED_OPEN;
      turn_d  = 14'sd0;
      blink_d = BLINK_STRAIGHT;
    end else begin
      mode_d  = MODE_AVOID;
      speed_d = feat_q.avoid_speed;
      turn_d  = feat_q.avoid_turn;
      blink_d = BLINK_AVOID;
    end
  end

  // Drive state, updated once per decided item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_path_time_q   <= 32'd0;
      reverse_deadline_q  <= 32'd0;
      reverse_seen_time_q <= 32'd0;
      prior_speed_q       <= 11'sd0;
    end else if (dec_fire) begin
      clear_path_time_q   <= clear_path_time_d;
      reverse_deadline_q  <= reverse_deadline_d;
      reverse_seen_time_q <= reverse_seen_time_d;
      prior_speed_q       <= speed_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= dec_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_fire) begin
      mode_q  <= mode_d;
      speed_q <= speed_d;
      turn_q  <= turn_d;
      blink_q <= blink_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, blink_q, turn_q, speed_q, mode_q};

  // A reverse result only ever turns fully or not at all.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (mode_q == MODE_REVERSE)) |->
      ((turn_q == TURN_FULL) || (turn_q == -TURN_FULL) || (turn_q == 14'sd0)))
    else $error("reverse turn outside full or zero");

  // A decided reverse item records its time as the last reverse time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_fire && reversing) |=> (reverse_seen_time_q == $past(time2_q)))
    else $error("reverse time not recorded");

  // An empty input register always takes a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while empty");

  // The prior speed is always zero, as after reset, or one of the commanded speeds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prior_speed_q == 11'sd0) || (prior_speed_q == SPEED_REVERSE)
      || ((prior_speed_q >= SPEED_MIN) && (prior_speed_q <= SPEED_MAX)))
    else $error("prior speed out of range");

endmodule
